[sv/tds_pkg.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver package
// Shared types, state encodings and default constants of the solver.
// ----------------------------------------------------------------------------
package tds_pkg;

    localparam int MAX_ROWS_DEF  = 16;
    localparam int FRAC_BITS_DEF = 16;

    // Row count after reset.
    localparam logic [4:0] ROWS_RESET = 5'd4;

    // Controller states.
    typedef enum logic [4:0] {
        S_LOAD,
        S_INIT_RD,
        S_INIT_TAKE,
        S_F_RD,
        S_F_DIV,
        S_F_WAIT,
        S_F_MUL_D,
        S_F_MUL_R,
        S_F_WB,
        S_LAST_DIV,
        S_LAST_WAIT,
        S_LAST_WB,
        S_B_RD,
        S_B_MUL,
        S_B_SUB,
        S_B_DIV,
        S_B_WAIT,
        S_B_WB,
        S_O_RD,
        S_O_LOAD,
        S_O_SEND
    } t_state;

    // Datapath operations, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_ROW,
        OP_TAKE_PREV,
        OP_DIV_FWD,
        OP_MUL_DIAG,
        OP_MUL_RHS,
        OP_FWD_WB,
        OP_DIV_LAST,
        OP_ANS_WB,
        OP_MUL_BACK,
        OP_SUB_BACK,
        OP_DIV_BACK,
        OP_OUT_LOAD
    } t_op;

    // Command from the controller to the datapath.
    typedef struct packed {
        t_op  op;
        logic clr_flag;
        logic last;
    } t_cmd;

endpackage

[sv/tds_if.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver channels
// Valid/ready channels for equation rows in and solution values out.
// ----------------------------------------------------------------------------
interface tds_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sub_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] super_coef;
    logic signed [31:0] rhs_value;

    modport source (output valid, sub_coef, diag_coef, super_coef, rhs_value, input ready);
    modport sink   (input valid, sub_coef, diag_coef, super_coef, rhs_value, output ready);
endinterface

interface tds_out_if;
    logic               valid;
    logic               ready;
    logic        [3:0]  row_index;
    logic signed [31:0] solution;
    logic               last;
    logic               zero_pivot;

    modport source (output valid, row_index, solution, last, zero_pivot, input ready);
    modport sink   (input valid, row_index, solution, last, zero_pivot, output ready);
endinterface

[sv/tds_div.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver divider
// Restoring divider, one quotient bit per cycle, computing the saturated
// fixed-point quotient (num << FRAC_BITS) / den, truncated toward zero.
// ----------------------------------------------------------------------------
module tds_div #(
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_num,
    input  logic signed [31:0] i_den,
    output logic               o_done,
    output logic signed [31:0] o_quo,
    output logic               o_zero
);

    localparam int NW  = 32 + FRAC_BITS;
    localparam int CNW = $clog2(NW + 1);

    logic           r_busy;
    logic           r_done;
    logic [CNW-1:0] r_cnt;
    logic [32:0]    r_rem;
    logic [NW-1:0]  r_nq;
    logic [31:0]    r_dv;
    logic           r_neg;
    logic           r_zero;

    logic [31:0]    abs_num;
    logic [31:0]    abs_den;
    logic [32:0]    trial;
    logic           fits;

    assign abs_num = i_num[31] ? 32'(-i_num) : 32'(i_num);
    assign abs_den = i_den[31] ? 32'(-i_den) : 32'(i_den);
    assign trial   = {r_rem[31:0], r_nq[NW-1]};
    assign fits    = trial >= {1'b0, r_dv};

    // Control: busy while the quotient bits are formed, then a one-cycle done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNW'(1);
                if (r_cnt == CNW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands and one restoring step a cycle.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq   <= {abs_num, {FRAC_BITS{1'b0}}};
            r_dv   <= abs_den;
            r_rem  <= '0;
            r_neg  <= i_num[31] ^ i_den[31];
            r_zero <= (i_den == 32'sd0);
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dv}) : trial;
            r_nq  <= {r_nq[NW-2:0], fits};
        end
    end

    // Sign and saturation of the finished quotient.
    always_comb begin
        if (r_zero) begin
            o_quo = 32'sd0;
        end else if (r_neg) begin
            if (r_nq > {{(NW-32){1'b0}}, 32'h8000_0000}) begin
                o_quo = 32'sh8000_0000;
            end else begin
                o_quo = 32'(-r_nq[31:0]);
            end
        end else begin
            if (r_nq > {{(NW-32){1'b0}}, 32'h7FFF_FFFF}) begin
                o_quo = 32'sh7FFF_FFFF;
            end else begin
                o_quo = 32'(r_nq[31:0]);
            end
        end
    end

    assign o_done = r_done;
    assign o_zero = r_zero;

endmodule

[sv/tds_datapath.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver datapath
// Row stores, previous-row registers, multiplier, saturating subtract,
// divider and output register, driven one operation a cycle.
// ----------------------------------------------------------------------------
module tds_datapath #(
    parameter int MAX_ROWS  = tds_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tds_pkg::t_cmd               i_cmd,
    input  logic [$clog2(MAX_ROWS)-1:0] i_addr,
    input  logic signed [31:0]          i_sub_coef,
    input  logic signed [31:0]          i_diag_coef,
    input  logic signed [31:0]          i_super_coef,
    input  logic signed [31:0]          i_rhs_value,
    output logic                        o_div_done,
    output logic [3:0]                  o_row_index,
    output logic signed [31:0]          o_solution,
    output logic                        o_last,
    output logic                        o_zero_pivot
);

    logic signed [31:0] r_sub_mem   [MAX_ROWS];
    logic signed [31:0] r_diag_mem  [MAX_ROWS];
    logic signed [31:0] r_super_mem [MAX_ROWS];
    logic signed [31:0] r_rhs_mem   [MAX_ROWS];
    logic signed [31:0] r_ans_mem   [MAX_ROWS];

    logic signed [31:0] r_rd_sub, r_rd_diag, r_rd_super, r_rd_rhs, r_rd_ans;
    logic signed [31:0] r_p_diag, r_p_super, r_p_rhs;
    logic signed [31:0] r_q, r_x, r_t, r_new_diag;
    logic signed [63:0] r_prod;
    logic               r_flag;
    logic [3:0]         r_o_idx;
    logic signed [31:0] r_o_sol;
    logic               r_o_last;
    logic               r_o_flag;

    logic               div_start;
    logic signed [31:0] div_num, div_den, div_quo;
    logic               div_done, div_zero;
    logic signed [31:0] prod_fx;
    logic signed [31:0] new_rhs;
    logic signed [31:0] back_t;

    // Product shifted down by the fraction width, then saturated.
    function automatic logic signed [31:0] f_shift_sat(input logic signed [63:0] p);
        logic signed [63:0] s;
        s = p >>> FRAC_BITS;
        if (s > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

    // Saturating 32-bit difference.
    function automatic logic signed [31:0] f_sub_sat(input logic signed [31:0] a,
                                                     input logic signed [31:0] b);
        logic [32:0] d;
        d = {a[31], a} - {b[31], b};
        if (d[32:31] == 2'b01) begin
            return 32'sh7FFF_FFFF;
        end else if (d[32:31] == 2'b10) begin
            return 32'sh8000_0000;
        end
        return d[31:0];
    endfunction

    assign prod_fx = f_shift_sat(r_prod);
    assign new_rhs = f_sub_sat(r_rd_rhs, prod_fx);
    assign back_t  = f_sub_sat(r_rd_rhs, prod_fx);

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_num   = r_t;
        div_den   = r_rd_diag;
        case (i_cmd.op)
            tds_pkg::OP_DIV_FWD: begin
                div_start = 1'b1;
                div_num   = r_rd_sub;
                div_den   = r_p_diag;
            end
            tds_pkg::OP_DIV_LAST: begin
                div_start = 1'b1;
                div_num   = r_p_rhs;
                div_den   = r_p_diag;
            end
            tds_pkg::OP_DIV_BACK: begin
                div_start = 1'b1;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    tds_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_zero  (div_zero)
    );

    // Row stores: written on load and write-back, read registered every cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == tds_pkg::OP_LOAD_ROW) begin
            r_sub_mem[i_addr]   <= i_sub_coef;
            r_diag_mem[i_addr]  <= i_diag_coef;
            r_super_mem[i_addr] <= i_super_coef;
            r_rhs_mem[i_addr]   <= i_rhs_value;
        end else if (i_cmd.op == tds_pkg::OP_FWD_WB) begin
            r_diag_mem[i_addr]  <= r_new_diag;
            r_rhs_mem[i_addr]   <= new_rhs;
        end
        if (i_cmd.op == tds_pkg::OP_ANS_WB) begin
            r_ans_mem[i_addr] <= r_q;
        end
        r_rd_sub   <= r_sub_mem[i_addr];
        r_rd_diag  <= r_diag_mem[i_addr];
        r_rd_super <= r_super_mem[i_addr];
        r_rd_rhs   <= r_rhs_mem[i_addr];
        r_rd_ans   <= r_ans_mem[i_addr];
    end

    // Working registers of elimination and substitution.
    always_ff @(posedge i_clk) begin
        if (div_done) begin
            r_q <= div_quo;
        end
        case (i_cmd.op)
            tds_pkg::OP_TAKE_PREV: begin
                r_p_diag  <= r_rd_diag;
                r_p_super <= r_rd_super;
                r_p_rhs   <= r_rd_rhs;
            end
            tds_pkg::OP_MUL_DIAG: begin
                r_prod <= r_q * r_p_super;
            end
            tds_pkg::OP_MUL_RHS: begin
                r_new_diag <= f_sub_sat(r_rd_diag, prod_fx);
                r_prod     <= r_q * r_p_rhs;
            end
            tds_pkg::OP_FWD_WB: begin
                r_p_diag  <= r_new_diag;
                r_p_rhs   <= new_rhs;
                r_p_super <= r_rd_super;
            end
            tds_pkg::OP_ANS_WB: begin
                r_x <= r_q;
            end
            tds_pkg::OP_MUL_BACK: begin
                r_prod <= r_rd_super * r_x;
            end
            tds_pkg::OP_SUB_BACK: begin
                r_t <= back_t;
            end
            tds_pkg::OP_OUT_LOAD: begin
                r_o_idx  <= 4'(i_addr);
                r_o_sol  <= r_rd_ans;
                r_o_last <= i_cmd.last;
                r_o_flag <= r_flag;
            end
            default: begin
                // Other operations leave the working registers as they are.
            end
        endcase
    end

    // Zero-pivot flag: cleared for a new system, set by any zero divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_cmd.clr_flag) begin
            r_flag <= 1'b0;
        end else if (div_done && div_zero) begin
            r_flag <= 1'b1;
        end
    end

    assign o_div_done   = div_done;
    assign o_row_index  = r_o_idx;
    assign o_solution   = r_o_sol;
    assign o_last       = r_o_last;
    assign o_zero_pivot = r_o_flag;

endmodule

[sv/tds_ctrl.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver controller
// Sequences row loading, forward elimination, back substitution and the
// delivery of solution values; holds the row-count register.
// ----------------------------------------------------------------------------
module tds_ctrl #(
    parameter int MAX_ROWS = tds_pkg::MAX_ROWS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [4:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_div_done,
    output tds_pkg::t_cmd               o_cmd,
    output logic [$clog2(MAX_ROWS)-1:0] o_addr
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);
    localparam int EW = (CW > 5) ? CW : 5;

    tds_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_idx, n_idx;
    logic [CW-1:0]   r_loaded, n_loaded;
    logic [4:0]      r_rows;
    logic [EW-1:0]   rows_ext;
    logic [CW-1:0]   rows_eff;
    logic [CW-1:0]   idx_inc;

    // Effective row count: zero acts as one, large values clamp.
    always_comb begin
        rows_ext = EW'(r_rows);
        if (rows_ext == '0) begin
            rows_ext = EW'(1);
        end else if (rows_ext > EW'(MAX_ROWS)) begin
            rows_ext = EW'(MAX_ROWS);
        end
        rows_eff = CW'(rows_ext);
    end

    assign idx_inc = r_idx + CW'(1);

    // State and counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tds_pkg::S_LOAD;
            r_idx    <= '0;
            r_loaded <= '0;
            r_rows   <= tds_pkg::ROWS_RESET;
        end else begin
            r_state  <= n_state;
            r_idx    <= n_idx;
            r_loaded <= n_loaded;
            if (i_cfg_we) begin
                r_rows <= i_cfg_data;
            end
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_loaded       = r_loaded;
        o_cmd.op       = tds_pkg::OP_NONE;
        o_cmd.clr_flag = 1'b0;
        o_cmd.last     = 1'b0;
        o_addr         = r_idx[AW-1:0];
        o_in_ready     = 1'b0;
        o_out_valid    = 1'b0;
        case (r_state)
            tds_pkg::S_LOAD: begin
                o_in_ready = 1'b1;
                o_addr     = r_loaded[AW-1:0];
                if (i_in_valid) begin
                    o_cmd.op       = tds_pkg::OP_LOAD_ROW;
                    o_cmd.clr_flag = (r_loaded == '0);
                    if (r_loaded + CW'(1) == rows_eff) begin
                        n_loaded = '0;
                        n_idx    = '0;
                        n_state  = tds_pkg::S_INIT_RD;
                    end else begin
                        n_loaded = r_loaded + CW'(1);
                    end
                end
            end
            tds_pkg::S_INIT_RD: begin
                n_state = tds_pkg::S_INIT_TAKE;
            end
            tds_pkg::S_INIT_TAKE: begin
                o_cmd.op = tds_pkg::OP_TAKE_PREV;
                n_idx    = CW'(1);
                n_state  = (rows_eff == CW'(1)) ? tds_pkg::S_LAST_DIV : tds_pkg::S_F_RD;
            end
            tds_pkg::S_F_RD: begin
                n_state = tds_pkg::S_F_DIV;
            end
            tds_pkg::S_F_DIV: begin
                o_cmd.op = tds_pkg::OP_DIV_FWD;
                n_state  = tds_pkg::S_F_WAIT;
            end
            tds_pkg::S_F_WAIT: begin
                if (i_div_done) begin
                    n_state = tds_pkg::S_F_MUL_D;
                end
            end
            tds_pkg::S_F_MUL_D: begin
                o_cmd.op = tds_pkg::OP_MUL_DIAG;
                n_state  = tds_pkg::S_F_MUL_R;
            end
            tds_pkg::S_F_MUL_R: begin
                o_cmd.op = tds_pkg::OP_MUL_RHS;
                n_state  = tds_pkg::S_F_WB;
            end
            tds_pkg::S_F_WB: begin
                o_cmd.op = tds_pkg::OP_FWD_WB;
                n_idx    = idx_inc;
                n_state  = (idx_inc == rows_eff) ? tds_pkg::S_LAST_DIV : tds_pkg::S_F_RD;
            end
            tds_pkg::S_LAST_DIV: begin
                o_cmd.op = tds_pkg::OP_DIV_LAST;
                n_idx    = rows_eff - CW'(1);
                n_state  = tds_pkg::S_LAST_WAIT;
            end
            tds_pkg::S_LAST_WAIT: begin
                if (i_div_done) begin
                    n_state = tds_pkg::S_LAST_WB;
                end
            end
            tds_pkg::S_LAST_WB, tds_pkg::S_B_WB: begin
                o_cmd.op = tds_pkg::OP_ANS_WB;
                if (r_idx == '0) begin
                    n_state = tds_pkg::S_O_RD;
                end else begin
                    n_idx   = r_idx - CW'(1);
                    n_state = tds_pkg::S_B_RD;
                end
            end
            tds_pkg::S_B_RD: begin
                n_state = tds_pkg::S_B_MUL;
            end
            tds_pkg::S_B_MUL: begin
                o_cmd.op = tds_pkg::OP_MUL_BACK;
                n_state  = tds_pkg::S_B_SUB;
            end
            tds_pkg::S_B_SUB: begin
                o_cmd.op = tds_pkg::OP_SUB_BACK;
                n_state  = tds_pkg::S_B_DIV;
            end
            tds_pkg::S_B_DIV: begin
                o_cmd.op = tds_pkg::OP_DIV_BACK;
                n_state  = tds_pkg::S_B_WAIT;
            end
            tds_pkg::S_B_WAIT: begin
                if (i_div_done) begin
                    n_state = tds_pkg::S_B_WB;
                end
            end
            tds_pkg::S_O_RD: begin
                n_state = tds_pkg::S_O_LOAD;
            end
            tds_pkg::S_O_LOAD: begin
                o_cmd.op   = tds_pkg::OP_OUT_LOAD;
                o_cmd.last = (idx_inc == rows_eff);
                n_state    = tds_pkg::S_O_SEND;
            end
            tds_pkg::S_O_SEND: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (idx_inc == rows_eff) begin
                        n_idx   = '0;
                        n_state = tds_pkg::S_LOAD;
                    end else begin
                        n_idx   = idx_inc;
                        n_state = tds_pkg::S_O_RD;
                    end
                end
            end
            default: begin
                n_state = tds_pkg::S_LOAD;
            end
        endcase
        // A configuration write discards a partly loaded system.
        if (i_cfg_we) begin
            n_loaded       = '0;
            o_cmd.clr_flag = 1'b1;
        end
    end

endmodule

[sv/tridiagonal_system_solver.sv]
// Rows load at one per cycle; the last row starts the solve.
// The solve runs forward elimination and then back substitution, each division
// taken by the shared bit-serial divider.
// Solutions leave in row order, each held until taken; one system is handled at a time.
// Reset (synchronous, active low) sets the row count to four and empties the block.
// ----------------------------------------------------------------------------
// Tridiagonal system solver
// Thomas-algorithm solver in signed fixed point: controller plus datapath.
// ----------------------------------------------------------------------------
module tridiagonal_system_solver #(
    parameter int MAX_ROWS  = tds_pkg::MAX_ROWS_DEF,
    parameter int FRAC_BITS = tds_pkg::FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [4:0] i_cfg_data,
    tds_in_if.sink     i_in,
    tds_out_if.source  o_out
);

    tds_pkg::t_cmd               cmd;
    logic [$clog2(MAX_ROWS)-1:0] addr;
    logic                        div_done;

    // Sequencer.
    tds_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_div_done  (div_done),
        .o_cmd       (cmd),
        .o_addr      (addr)
    );

    // Arithmetic and storage.
    tds_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_addr       (addr),
        .i_sub_coef   (i_in.sub_coef),
        .i_diag_coef  (i_in.diag_coef),
        .i_super_coef (i_in.super_coef),
        .i_rhs_value  (i_in.rhs_value),
        .o_div_done   (div_done),
        .o_row_index  (o_out.row_index),
        .o_solution   (o_out.solution),
        .o_last       (o_out.last),
        .o_zero_pivot (o_out.zero_pivot)
    );

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// Tridiagonal solver testbench
// Loads equation rows through the input channel and compares every solution
// value with a fixed-point Thomas-algorithm predictor. Row counts from one to
// sixteen are used, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

    localparam int FB = tds_pkg::FRAC_BITS_DEF;
    localparam int NR = tds_pkg::MAX_ROWS_DEF;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic signed [31:0] sub_coef;
        logic signed [31:0] diag_coef;
        logic signed [31:0] super_coef;
        logic signed [31:0] rhs_value;
    } t_row;

    typedef struct packed {
        logic [3:0]         row_index;
        logic signed [31:0] solution;
        logic               last;
        logic               zero_pivot;
    } t_answer;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [4:0] i_cfg_data;

    tds_in_if  in_ch ();
    tds_out_if out_ch ();

    tridiagonal_system_solver u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Predictor state.
    logic [4:0]  rows_setting;
    int          rows_held;
    logic        singular;
    longint      sub_mem [NR];
    longint      diag_mem [NR];
    longint      super_mem [NR];
    longint      rhs_mem [NR];
    longint      x_mem [NR];

    t_row    pending_rows [$];
    t_answer expected_answers [$];
    int      mismatches;
    longint  cycle_count;
    int      send_gap;
    int      take_gap;
    bit      stim_done;

    // Clock.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint fx_product(longint a, longint b);
        longint p;
        p = a * b;
        return clamp32(p >>> FB);
    endfunction

    function automatic longint fx_quotient(longint num, longint den);
        longint un;
        longint ud;
        longint q;
        bit neg;
        if (den == 0) begin
            singular = 1'b1;
            return 0;
        end
        neg = (num < 0) != (den < 0);
        un = (num < 0 ? -num : num) <<< FB;
        ud = den < 0 ? -den : den;
        q = un / ud;
        if (neg) return (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
        return (q > 64'sd2147483647) ? 64'sd2147483647 : q;
    endfunction

    function automatic int active_rows();
        int n;
        n = rows_setting;
        if (n < 1) n = 1;
        if (n > NR) n = NR;
        return n;
    endfunction

    // Loads one row and, on the row that completes a system, solves it.
    function automatic void predict_row(t_row r);
        int n;
        int k;
        longint m;
        longint t;
        t_answer a;
        n = active_rows();
        k = rows_held;
        if (k >= n) k = 0;
        if (k == 0) singular = 1'b0;
        sub_mem[k]   = r.sub_coef;
        diag_mem[k]  = r.diag_coef;
        super_mem[k] = r.super_coef;
        rhs_mem[k]   = r.rhs_value;
        k++;
        if (k < n) begin
            rows_held = k;
            return;
        end
        rows_held = 0;
        for (int i = 1; i < n; i++) begin
            m = fx_quotient(sub_mem[i], diag_mem[i-1]);
            diag_mem[i] = clamp32(diag_mem[i] - fx_product(m, super_mem[i-1]));
            rhs_mem[i]  = clamp32(rhs_mem[i] - fx_product(m, rhs_mem[i-1]));
        end
        x_mem[n-1] = fx_quotient(rhs_mem[n-1], diag_mem[n-1]);
        for (int i = n - 2; i >= 0; i--) begin
            t = clamp32(rhs_mem[i] - fx_product(super_mem[i], x_mem[i+1]));
            x_mem[i] = fx_quotient(t, diag_mem[i]);
        end
        for (int i = 0; i < n; i++) begin
            a.row_index  = i[3:0];
            a.solution   = x_mem[i][31:0];
            a.last       = (i == n - 1);
            a.zero_pivot = singular;
            expected_answers.push_back(a);
        end
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 45) return 0;
        if (sel < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return $urandom();
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    // Well-conditioned rows with a dominant diagonal, and now and then raw noise.
    function automatic t_row rand_row();
        t_row r;
        if ($urandom_range(0, 9) < 7) begin
            r.sub_coef   = $signed(32'($urandom_range(0, 20'hFFFFF))) - 32'sh80000;
            r.super_coef = $signed(32'($urandom_range(0, 20'hFFFFF))) - 32'sh80000;
            r.diag_coef  = 32'($urandom_range(32'h200000, 32'h1000000));
            if ($urandom_range(0, 1)) r.diag_coef = -r.diag_coef;
            r.rhs_value  = $urandom();
            r.rhs_value  = r.rhs_value >>> $urandom_range(0, 12);
        end else begin
            r.sub_coef   = rand_word();
            r.diag_coef  = ($urandom_range(0, 7) == 0) ? 32'd0 : rand_word();
            r.super_coef = rand_word();
            r.rhs_value  = rand_word();
        end
        return r;
    endfunction

    function automatic t_row make_row(logic [31:0] s, logic [31:0] d, logic [31:0] u,
                                      logic [31:0] b);
        t_row r;
        r.sub_coef = s;
        r.diag_coef = d;
        r.super_coef = u;
        r.rhs_value = b;
        return r;
    endfunction

    // Input driver: one row per transfer, random gaps between rows.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_ch.ready) begin
            // Hold the row until it is taken.
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            in_ch.valid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
            {in_ch.sub_coef, in_ch.diag_coef, in_ch.super_coef, in_ch.rhs_value}
                <= pending_rows[0];
            predict_row(pending_rows.pop_front());
            in_ch.valid <= 1'b1;
            send_gap <= pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Output monitor: compares each transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.row_index, out_ch.solution, out_ch.last, out_ch.zero_pivot};
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected solution value: row %0d value %h",
                                 got.row_index, got.solution);
                end else begin
                    want = expected_answers.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: exp %0d %h %b %b, got %0d %h %b %b",
                                     want.row_index, want.solution, want.last,
                                     want.zero_pivot, got.row_index, got.solution,
                                     got.last, got.zero_pivot);
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap <= take_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) take_gap <= pick_gap();
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_rows.size() > 0 || in_ch.valid || expected_answers.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_rows(logic [4:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        rows_setting = value;
        rows_held    = 0;
        singular     = 1'b0;
    endtask

    // Stimulus: a directed phase, then random systems under several row counts.
    initial begin
        int sent;
        logic [4:0] setting;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.sub_coef = '0;
        in_ch.diag_coef = '0;
        in_ch.super_coef = '0;
        in_ch.rhs_value = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_gap = 0;
        take_gap = 0;
        rows_setting = tds_pkg::ROWS_RESET;
        rows_held = 0;
        singular = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset row count of four: identity, extremes and a zero pivot.
        pending_rows.push_back(make_row(32'h7FFF_FFFF, 32'h0001_0000, 32'h8000_0000,
                                        32'h0003_0000));
        pending_rows.push_back(make_row(32'h0000_0000, 32'h0001_0000, 32'h0, 32'h7FFF_FFFF));
        pending_rows.push_back(make_row(32'h0000_0000, 32'h0000_0001, 32'h0, 32'h8000_0000));
        pending_rows.push_back(make_row(32'hFFFF_0000, 32'h0002_0000, 32'hFFFF_FFFF,
                                        32'hFFFF_FFFF));
        pending_rows.push_back(make_row(32'h1, 32'h0, 32'h1, 32'h0001_0000));
        pending_rows.push_back(make_row(32'h0001_0000, 32'h0004_0000, 32'h1, 32'h2));
        pending_rows.push_back(make_row(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                        32'h8000_0000));
        pending_rows.push_back(make_row(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF));
        wait_drained();

        // Single row (zero setting acts as one), then overlarge setting.
        write_rows(5'd0);
        pending_rows.push_back(make_row(32'h0, 32'h0, 32'h0, 32'h0001_0000));
        pending_rows.push_back(make_row(32'h0, 32'hFFFF_0000, 32'h0, 32'h7FFF_FFFF));
        pending_rows.push_back(make_row(32'h0, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF));
        wait_drained();
        write_rows(5'd31);
        for (int i = 0; i < 16; i++) pending_rows.push_back(rand_row());
        wait_drained();

        // Partly loaded system discarded by a register write.
        write_rows(5'd3);
        pending_rows.push_back(rand_row());
        wait_drained();

        sent = 0;
        while (sent < 300) begin
            case ($urandom_range(0, 5))
                0: setting = 5'd1;
                1: setting = 5'd2;
                2: setting = 5'd16;
                3: setting = 5'($urandom_range(17, 31));
                default: setting = 5'($urandom_range(0, 8));
            endcase
            write_rows(setting);
            for (int s = 0; s < 3; s++) begin
                for (int i = 0; i < active_rows(); i++) pending_rows.push_back(rand_row());
                sent += active_rows();
            end
            wait_drained();
        end

        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
